/* hw/rtl/command_frame_parser_top_defines.svh */
// assertion macros shared by the command frame parser checker
// clk_i and rst_ni must be visible where the macros are used
`ifndef COMMAND_FRAME_PARSER_TOP_DEFINES_SVH
`define COMMAND_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define CFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cfp_pkg.sv */
// types, byte codes and reset values for the command frame parser
// no dependencies
`timescale 1ns / 1ps

package cfp_pkg;

  // frame byte codes
  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] TYPE_TONE  = 8'h04;
  localparam logic [7:0] TYPE_LIMIT = 8'h02;
  localparam logic [7:0] CTRL_TONE  = 8'h11;
  localparam logic [7:0] MODE_ALT   = 8'h31;
  localparam logic [7:0] MODE_SWEEP = 8'h32;
  localparam logic [7:0] MODE_SINE  = 8'h33;
  localparam logic [7:0] CTRL_TEMP  = 8'h41;
  localparam logic [7:0] CTRL_LIGHT = 8'h42;
  localparam logic [7:0] CHECK_BYTE = 8'h00;

  // frame positions
  localparam logic [3:0] POS_IDLE  = 4'd0;
  localparam logic [3:0] POS_SRC   = 4'd1;
  localparam logic [3:0] POS_DST   = 4'd2;
  localparam logic [3:0] POS_TYPE  = 4'd3;
  localparam logic [3:0] POS_CTRL  = 4'd4;
  localparam logic [3:0] POS_MODE  = 4'd5;
  localparam logic [3:0] POS_TONEL = 4'd6;
  localparam logic [3:0] POS_TONEH = 4'd7;
  localparam logic [3:0] POS_CHECK = 4'd8;

  // configuration register indexes
  localparam logic CFG_EXP_SRC = 1'b0;
  localparam logic CFG_EXP_DST = 1'b1;

  // reset values
  localparam logic [7:0]  EXP_SRC_RST   = 8'd1;
  localparam logic [7:0]  EXP_DST_RST   = 8'd2;
  localparam logic [11:0] LOW_TONE_RST  = 12'd200;
  localparam logic [11:0] HIGH_TONE_RST = 12'd4000;

  // kept frame state
  typedef struct packed {
    logic [3:0]  position;
    logic [7:0]  type_byte;
    logic [7:0]  control_byte;
    logic [7:0]  mode_byte;
    logic [1:0]  mode_code;
    logic [2:0]  indicators;
    logic [11:0] low_tone;
    logic [11:0] high_tone;
    logic [7:0]  light_limit;
    logic [7:0]  temp_limit;
  } cfp_state_t;

  // frame state after reset
  localparam cfp_state_t STATE_RST = '{
    position:     POS_IDLE,
    type_byte:    8'd0,
    control_byte: 8'd0,
    mode_byte:    8'd0,
    mode_code:    2'd0,
    indicators:   3'd0,
    low_tone:     LOW_TONE_RST,
    high_tone:    HIGH_TONE_RST,
    light_limit:  8'd0,
    temp_limit:   8'd0
  };

  // one status result
  typedef struct packed {
    logic [3:0]  frame_position;
    logic        byte_accepted;
    logic        frame_complete;
    logic [1:0]  alarm_mode;
    logic [2:0]  indicator_mask;
    logic [11:0] low_tone;
    logic [11:0] high_tone;
    logic [7:0]  light_threshold;
    logic [7:0]  temp_threshold;
  } cfp_result_t;

  function automatic logic is_mode(input logic [7:0] b);
    return (b == MODE_ALT) || (b == MODE_SWEEP) || (b == MODE_SINE);
  endfunction

endpackage

/* hw/rtl/cfp_step.sv */
// next-state and status logic for one received byte
// depends on cfp_pkg
`timescale 1ns / 1ps

module cfp_step (
  input  cfp_pkg::cfp_state_t  state_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           exp_src_i,
  input  logic [7:0]           exp_dst_i,
  output cfp_pkg::cfp_state_t  state_o,
  output cfp_pkg::cfp_result_t result_o
);
  import cfp_pkg::*;

  logic       acc;
  logic       done;
  logic [2:0] ind_bit;

  // indicator bit picked by the mode byte
  always_comb begin
    case (rx_byte_i)
      MODE_ALT:   ind_bit = 3'b001;
      MODE_SWEEP: ind_bit = 3'b010;
      MODE_SINE:  ind_bit = 3'b100;
      default:    ind_bit = 3'b000;
    endcase
  end

  // rule chain, first match wins
  always_comb begin
    state_o = state_i;
    acc     = 1'b1;
    done    = 1'b0;
    if (rx_byte_i == SYNC_BYTE) begin
      state_o.type_byte    = 8'd0;
      state_o.control_byte = 8'd0;
      state_o.mode_byte    = 8'd0;
      state_o.position     = POS_SRC;
    end else if (state_i.position == POS_SRC && rx_byte_i == exp_src_i) begin
      state_o.position = POS_DST;
    end else if (state_i.position == POS_DST && rx_byte_i == exp_dst_i) begin
      state_o.position = POS_TYPE;
    end else if (state_i.position == POS_TYPE && rx_byte_i == TYPE_TONE) begin
      state_o.type_byte = rx_byte_i;
      state_o.position  = POS_CTRL;
    end else if (state_i.position == POS_CTRL && rx_byte_i == CTRL_TONE &&
                 state_i.type_byte == TYPE_TONE) begin
      state_o.control_byte = rx_byte_i;
      state_o.position     = POS_MODE;
    end else if (state_i.position == POS_MODE && is_mode(rx_byte_i) &&
                 state_i.control_byte == CTRL_TONE) begin
      state_o.mode_byte  = rx_byte_i;
      state_o.mode_code  = rx_byte_i[1:0];
      state_o.indicators = state_i.indicators | ind_bit;
      state_o.position   = POS_TONEL;
    end else if (state_i.position == POS_TONEL && is_mode(state_i.mode_byte)) begin
      state_o.low_tone = {4'd0, rx_byte_i};
      state_o.position = POS_TONEH;
    end else if (state_i.position == POS_TONEH) begin
      state_o.high_tone = {4'd0, rx_byte_i};
      state_o.position  = POS_CHECK;
    end else if (state_i.position == POS_CHECK && rx_byte_i == CHECK_BYTE) begin
      state_o.position = POS_IDLE;
      done             = 1'b1;
    end else if (state_i.position == POS_TYPE && rx_byte_i == TYPE_LIMIT) begin
      state_o.type_byte = rx_byte_i;
      state_o.position  = POS_CTRL;
    end else if (state_i.position == POS_CTRL && rx_byte_i == CTRL_TEMP &&
                 state_i.type_byte == TYPE_LIMIT) begin
      state_o.control_byte = rx_byte_i;
      state_o.position     = POS_MODE;
    end else if (state_i.position == POS_MODE && state_i.control_byte == CTRL_TEMP) begin
      state_o.temp_limit = rx_byte_i;
      state_o.mode_byte  = rx_byte_i;
      state_o.position   = POS_TONEL;
    end else if (state_i.position == POS_CTRL && rx_byte_i == CTRL_LIGHT &&
                 state_i.type_byte == TYPE_LIMIT) begin
      state_o.control_byte = rx_byte_i;
      state_o.position     = POS_MODE;
    end else if (state_i.position == POS_MODE && state_i.control_byte == CTRL_LIGHT) begin
      state_o.light_limit = rx_byte_i;
      state_o.mode_byte   = rx_byte_i;
      state_o.position    = POS_TONEL;
    end else if (state_i.position == POS_TONEL && rx_byte_i == CHECK_BYTE) begin
      state_o.position = POS_IDLE;
      done             = 1'b1;
    end else begin
      acc = 1'b0;
    end
  end

  // status seen after this byte
  always_comb begin
    result_o.frame_position  = state_o.position;
    result_o.byte_accepted   = acc;
    result_o.frame_complete  = done;
    result_o.alarm_mode      = state_o.mode_code;
    result_o.indicator_mask  = state_o.indicators;
    result_o.low_tone        = state_o.low_tone;
    result_o.high_tone       = state_o.high_tone;
    result_o.light_threshold = state_o.light_limit;
    result_o.temp_threshold  = state_o.temp_limit;
  end

endmodule

/* hw/rtl/cfp_out_reg.sv */
// result register on the output channel
// depends on cfp_pkg
`timescale 1ns / 1ps

module cfp_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  cfp_pkg::cfp_result_t result_i,
  input  logic                 out_stall_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  output cfp_pkg::cfp_result_t result_o
);
  import cfp_pkg::*;

  logic        valid_q, valid_d;
  cfp_result_t data_q;

  // free when empty or when the held request leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

/* hw/rtl/command_frame_parser_top.sv */
// Command frame parser, top level.
//
// Input channel: in_valid_i / in_stall_o with one received byte, rx_byte_i.
// Output channel: out_valid_o / out_stall_i with one status request per byte:
// the frame position expected next, accept and complete flags, and the kept
// alarm mode, indicator mask, tone and threshold settings.
// Configuration: cfg_we_i writes cfg_wdata_i to the expected source byte
// (index 0) or the expected destination byte (index 1); write only when idle.
// From input accept to result valid, the byte lands in an input register, then
// the rule chain updates the frame state and loads the result register.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single rule-chain pass between those two registers.
// Reset clears both channels, sets position 0, tones 200 and 4000, all kept
// bytes and thresholds to zero, and the expected source and destination to
// 1 and 2. While the receiver stalls the result is held, one more byte may
// sit in the input register, and in_stall_o rises once that register is full.
// depends on cfp_pkg, cfp_step, cfp_out_reg
`timescale 1ns / 1ps

module command_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  frame_position_o,
  output logic        byte_accepted_o,
  output logic        frame_complete_o,
  output logic [1:0]  alarm_mode_o,
  output logic [2:0]  indicator_mask_o,
  output logic [11:0] low_tone_o,
  output logic [11:0] high_tone_o,
  output logic [7:0]  light_threshold_o,
  output logic [7:0]  temp_threshold_o
);
  import cfp_pkg::*;

  logic [7:0]  src_q, src_d;
  logic [7:0]  dst_q, dst_d;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_ready;
  logic        fire;
  cfp_state_t  state_q, state_d;
  cfp_result_t step_result;
  cfp_result_t out_result;

  // configuration register writes
  always_comb begin
    src_d = src_q;
    dst_d = dst_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EXP_SRC: src_d = cfg_wdata_i;
        CFG_EXP_DST: dst_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= EXP_SRC_RST;
      dst_q <= EXP_DST_RST;
    end else begin
      src_q <= src_d;
      dst_q <= dst_d;
    end
  end

  // input register, refilled whenever its byte moves on
  assign in_stall_o = in_valid_q && !out_ready;
  assign fire       = in_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // rule chain
  cfp_step u_step (
    .state_i   (state_q),
    .rx_byte_i (in_byte_q),
    .exp_src_i (src_q),
    .exp_dst_i (dst_q),
    .state_o   (state_d),
    .result_o  (step_result)
  );

  // frame state advances with each byte handed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result register
  cfp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_valid_q),
    .result_i    (step_result),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign frame_position_o  = out_result.frame_position;
  assign byte_accepted_o   = out_result.byte_accepted;
  assign frame_complete_o  = out_result.frame_complete;
  assign alarm_mode_o      = out_result.alarm_mode;
  assign indicator_mask_o  = out_result.indicator_mask;
  assign low_tone_o        = out_result.low_tone;
  assign high_tone_o       = out_result.high_tone;
  assign light_threshold_o = out_result.light_threshold;
  assign temp_threshold_o  = out_result.temp_threshold;

endmodule

/* hw/rtl/cfp_checker.sv */
// port-level checks for the command frame parser, bound to the top level
// depends on command_frame_parser_top_defines.svh
`timescale 1ns / 1ps
`include "command_frame_parser_top_defines.svh"

module cfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  frame_position_o,
  input logic        byte_accepted_o,
  input logic        frame_complete_o,
  input logic [1:0]  alarm_mode_o,
  input logic [2:0]  indicator_mask_o
);

  // a stalled status request stays put
  `CFP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(frame_position_o) && $stable(indicator_mask_o), "stalled result changed")

  // a completed frame was accepted and returns to idle
  `CFP_ASSERT_NOW(a_complete, out_valid_o && frame_complete_o, byte_accepted_o && frame_position_o == 4'd0, "complete flag without idle position")

  // position never runs past the check byte
  `CFP_ASSERT_NOW(a_pos_range, out_valid_o, frame_position_o <= 4'd8, "frame position out of range")

  // a nonzero alarm mode always comes with an indicator bit set
  `CFP_ASSERT_NOW(a_mode_ind, out_valid_o && alarm_mode_o != 2'd0, indicator_mask_o != 3'd0, "alarm mode without indicator")

  // input can only stall while the output is held up
  `CFP_ASSERT_NOW(a_in_stall, in_stall_o, out_valid_o && out_stall_i, "input stalled with output free")

endmodule

bind command_frame_parser_top cfp_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .frame_position_o (frame_position_o),
  .byte_accepted_o  (byte_accepted_o),
  .frame_complete_o (frame_complete_o),
  .alarm_mode_o     (alarm_mode_o),
  .indicator_mask_o (indicator_mask_o)
);
